### rtl/utf8_utf16_transcoder_macros.svh
// ----------------------------------------------------------------------------
// utf8_utf16_transcoder assertion macros
// shared concurrent assertion forms, clocked on clock, quiet in reset
// ----------------------------------------------------------------------------
`ifndef UTF8_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_UTF16_TRANSCODER_MACROS_SVH

// condition holds at every edge
`define U8U16_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication
`define U8U16_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define U8U16_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// types and constants of the utf-8 / utf-16 transcoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8u16_pkg;

   localparam int CP_W        = 31;
   localparam int UNIT_W      = 16;
   localparam int MAX_RESULTS = 4;

   localparam logic [CP_W-1:0] CP_SURR_LO = 31'h0000_D800;
   localparam logic [CP_W-1:0] CP_SURR_HI = 31'h0000_DFFF;
   localparam logic [CP_W-1:0] CP_MAX     = 31'h0010_FFFF;
   localparam logic [CP_W-1:0] CP_SUPP    = 31'h0001_0000;
   localparam logic [CP_W-1:0] CP_BMP_MAX = 31'h0000_FFFF;
   localparam logic [CP_W-1:0] CP_1B_MAX  = 31'h0000_007F;
   localparam logic [CP_W-1:0] CP_2B_MAX  = 31'h0000_07FF;

   localparam logic [UNIT_W-1:0] SURR_MASK = 16'hFC00;
   localparam logic [UNIT_W-1:0] HIGH_SURR = 16'hD800;
   localparam logic [UNIT_W-1:0] LOW_SURR  = 16'hDC00;

   // register indexes
   localparam logic REG_SOURCE_FORMAT = 1'b0;
   localparam logic REG_DEST_FORMAT   = 1'b1;

   typedef enum logic {
      FMT_UTF8,
      FMT_UTF16
   } fmt_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_UNIT,
      ST_BAD_CP,
      ST_INCOMPLETE
   } status_type;

   typedef struct packed {
      fmt_type                source_format;
      fmt_type                dest_format;
      logic [UNIT_W-1:0]      code_unit;
      logic                   end_of_source;
      logic [CP_W-1:0]        partial_code;
      logic [2:0]             units_remaining;
   } dec_in_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0][UNIT_W-1:0] units;
      logic [2:0]                         count;
      status_type                         status;
      logic [CP_W-1:0]                    code_point;
      logic [UNIT_W-1:0]                  bad_unit;
      logic [CP_W-1:0]                    partial_code;
      logic [2:0]                         units_remaining;
   } dec_out_type;

endpackage

### rtl/u8u16_req_if.sv
// ----------------------------------------------------------------------------
// u8u16_req_if
// request channel: one source code unit per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8u16_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        end_of_source;

   modport source (output valid, code_unit, end_of_source, input ready);
   modport sink   (input valid, code_unit, end_of_source, output ready);
endinterface

### rtl/u8u16_rsp_if.sv
// ----------------------------------------------------------------------------
// u8u16_rsp_if
// result channel: one destination unit or error report per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_unit;
   logic        char_done;
   logic [1:0]  status;
   logic [30:0] code_point;
   logic [15:0] bad_unit;

   modport source (output valid, out_unit, char_done, status, code_point, bad_unit,
                   input ready);
   modport sink   (input valid, out_unit, char_done, status, code_point, bad_unit,
                   output ready);
endinterface

### rtl/utf8_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_utf16_transcoder
// streams utf-8 bytes or utf-16 words in and transcoded units out
// ----------------------------------------------------------------------------
// req_ch carries one source code unit per request, with end_of_source on the
// last unit of a stream. rsp_ch carries one destination unit per transfer,
// or a single error report with char_done set.
// source_format and dest_format are written over the csr_ apb port at byte
// addresses 0 and 4; a write drops any character in progress. writes must be
// made only while no request is in flight; the block does not enforce this.
// a request is held in an input register, then decoded combinationally into a
// result buffer of up to four units; the first result shows from the result
// buffer, which loads from the input register once the buffer is free.
// throughput is one request per cycle while each request gives at most one
// result and the receiver does not stall; a character of n units holds the
// buffer while the single result port drains it, one unit a cycle unless stalled.
// when the receiver stalls, the buffer holds and one more request is taken
// into the input register before req_ch.ready drops.
// reset clears both formats to utf-8, drops the partial character and
// empties both registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_utf16_transcoder_macros.svh"

module utf8_utf16_transcoder
   import u8u16_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   u8u16_req_if.sink          req_ch,
   u8u16_rsp_if.source        rsp_ch,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   fmt_type src_fmt_ff, src_fmt_in;
   fmt_type dst_fmt_ff, dst_fmt_in;

   logic [CP_W-1:0] partial_ff, partial_in;
   logic [2:0]      rem_ff, rem_in;

   logic              in_valid_ff, in_valid_in;
   logic [UNIT_W-1:0] in_unit_ff;
   logic              in_eos_ff;

   logic [MAX_RESULTS-1:0][UNIT_W-1:0] unit_ff;
   status_type                         status_ff;
   logic [CP_W-1:0]                    cp_ff;
   logic [UNIT_W-1:0]                  bad_ff;
   logic [2:0]                         cnt_ff, cnt_in;
   logic [1:0]                         idx_ff, idx_in;

   dec_in_type  dec_in;
   dec_out_type dec_out;

   logic csr_write;
   logic req_take;
   logic rsp_take;
   logic rsp_last;
   logic load;

   // config port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_SOURCE_FORMAT: csr_prdata = {31'b0, src_fmt_ff};
         REG_DEST_FORMAT:   csr_prdata = {31'b0, dst_fmt_ff};
      endcase
   end

   always_comb begin
      src_fmt_in = src_fmt_ff;
      dst_fmt_in = dst_fmt_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_SOURCE_FORMAT: src_fmt_in = fmt_type'(csr_pwdata[0]);
            REG_DEST_FORMAT:   dst_fmt_in = fmt_type'(csr_pwdata[0]);
         endcase
      end
   end

   // handshake control
   assign rsp_ch.valid = (cnt_ff != 3'd0);
   assign rsp_take     = rsp_ch.valid && rsp_ch.ready;
   assign rsp_last     = ({1'b0, idx_ff} == (cnt_ff - 3'd1));
   assign load         = in_valid_ff && ((cnt_ff == 3'd0) || (rsp_take && rsp_last));
   assign req_ch.ready = !in_valid_ff || load;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign dec_in.source_format   = src_fmt_ff;
   assign dec_in.dest_format     = dst_fmt_ff;
   assign dec_in.code_unit       = in_unit_ff;
   assign dec_in.end_of_source   = in_eos_ff;
   assign dec_in.partial_code    = partial_ff;
   assign dec_in.units_remaining = rem_ff;

   u8u16_decode u_decode (
      .dec_in  (dec_in),
      .dec_out (dec_out)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      partial_in = partial_ff;
      rem_in     = rem_ff;
      if (csr_write) begin
         partial_in = '0;
         rem_in     = 3'd0;
      end else if (load) begin
         partial_in = dec_out.partial_code;
         rem_in     = dec_out.units_remaining;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = dec_out.count;
         idx_in = 2'd0;
      end else if (rsp_take) begin
         if (rsp_last) begin
            cnt_in = 3'd0;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_fmt_ff  <= FMT_UTF8;
         dst_fmt_ff  <= FMT_UTF8;
         partial_ff  <= '0;
         rem_ff      <= 3'd0;
         in_valid_ff <= 1'b0;
         cnt_ff      <= 3'd0;
         idx_ff      <= 2'd0;
      end else begin
         src_fmt_ff  <= src_fmt_in;
         dst_fmt_ff  <= dst_fmt_in;
         partial_ff  <= partial_in;
         rem_ff      <= rem_in;
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         idx_ff      <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_unit_ff <= req_ch.code_unit;
         in_eos_ff  <= req_ch.end_of_source;
      end
      if (load) begin
         unit_ff   <= dec_out.units;
         status_ff <= dec_out.status;
         cp_ff     <= dec_out.code_point;
         bad_ff    <= dec_out.bad_unit;
      end
   end

   assign rsp_ch.out_unit   = unit_ff[idx_ff];
   assign rsp_ch.char_done  = rsp_last;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.code_point = cp_ff;
   assign rsp_ch.bad_unit   = bad_ff;

   `U8U16_ASSERT_IMPLIES(a_idx_in_range, rsp_ch.valid, {1'b0, idx_ff} < cnt_ff, "index past count")
   `U8U16_ASSERT_ALWAYS(a_cnt_max, cnt_ff <= 3'(MAX_RESULTS), "result count too large")
   `U8U16_ASSERT_IMPLIES(a_err_single, rsp_ch.valid && status_ff != ST_OK, cnt_ff == 3'd1, "error not single")
   `U8U16_ASSERT_NEXT(a_idx_step, rsp_take && !rsp_last, idx_ff == $past(idx_ff) + 2'd1, "index did not step")
   `U8U16_ASSERT_IMPLIES(a_ready_empty, !in_valid_ff, req_ch.ready, "ready low with empty input register")

endmodule

### rtl/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// decodes one source unit against the partial character and produces the
// next partial state and all destination units or the error report
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8u16_decode
   import u8u16_pkg::*;
(
   input  dec_in_type  dec_in,
   output dec_out_type dec_out
);

   always_comb begin
      logic [7:0]        b;
      logic [UNIT_W-1:0] u;
      logic              do_emit;
      logic [CP_W-1:0]   emit_cp;
      logic              err;
      status_type        err_status;
      logic [UNIT_W-1:0] err_bad;
      logic [CP_W-1:0]   next_partial;
      logic [2:0]        next_rem;
      logic [20:0]       cp21;
      logic [20:0]       v;

      b            = dec_in.code_unit[7:0];
      u            = dec_in.code_unit;
      do_emit      = 1'b0;
      emit_cp      = '0;
      err          = 1'b0;
      err_status   = ST_OK;
      err_bad      = '0;
      next_partial = dec_in.partial_code;
      next_rem     = dec_in.units_remaining;

      if (dec_in.source_format == FMT_UTF8) begin
         if (dec_in.units_remaining == 3'd0) begin
            if (!b[7]) begin
               do_emit = 1'b1;
               emit_cp = {23'b0, b};
            end else begin
               unique casez (b)
                  8'b110?????: begin
                     next_partial = {26'b0, b[4:0]};
                     next_rem     = 3'd1;
                  end
                  8'b1110????: begin
                     next_partial = {27'b0, b[3:0]};
                     next_rem     = 3'd2;
                  end
                  8'b11110???: begin
                     next_partial = {28'b0, b[2:0]};
                     next_rem     = 3'd3;
                  end
                  8'b111110??: begin
                     next_partial = {29'b0, b[1:0]};
                     next_rem     = 3'd4;
                  end
                  8'b1111110?: begin
                     next_partial = {30'b0, b[0]};
                     next_rem     = 3'd5;
                  end
                  default: begin
                     // bare continuation, 0xfe, 0xff
                     err        = 1'b1;
                     err_status = ST_BAD_UNIT;
                     err_bad    = {8'b0, b};
                  end
               endcase
               if (!err && dec_in.end_of_source) begin
                  err        = 1'b1;
                  err_status = ST_INCOMPLETE;
               end
            end
         end else begin
            if (b[7:6] != 2'b10) begin
               err        = 1'b1;
               err_status = ST_BAD_UNIT;
               err_bad    = {8'b0, b};
            end else begin
               next_partial = {dec_in.partial_code[24:0], b[5:0]};
               next_rem     = dec_in.units_remaining - 3'd1;
               if (next_rem == 3'd0) begin
                  do_emit = 1'b1;
                  emit_cp = next_partial;
               end else if (dec_in.end_of_source) begin
                  err        = 1'b1;
                  err_status = ST_INCOMPLETE;
               end
            end
         end
      end else begin
         if (dec_in.units_remaining == 3'd0) begin
            if ((u & SURR_MASK) == HIGH_SURR) begin
               next_partial = {15'b0, u};
               next_rem     = 3'd1;
               if (dec_in.end_of_source) begin
                  err        = 1'b1;
                  err_status = ST_INCOMPLETE;
               end
            end else if ((u & SURR_MASK) == LOW_SURR) begin
               err        = 1'b1;
               err_status = ST_BAD_UNIT;
               err_bad    = u;
            end else begin
               do_emit = 1'b1;
               emit_cp = {15'b0, u};
            end
         end else begin
            if ((u & SURR_MASK) != LOW_SURR) begin
               err        = 1'b1;
               err_status = ST_BAD_UNIT;
               err_bad    = u;
            end else begin
               do_emit = 1'b1;
               emit_cp = {11'b0, dec_in.partial_code[9:0], u[9:0]} + CP_SUPP;
            end
         end
      end

      cp21 = emit_cp[20:0];
      v    = cp21 - CP_SUPP[20:0];

      dec_out                 = '0;
      dec_out.status          = ST_OK;
      dec_out.partial_code    = next_partial;
      dec_out.units_remaining = next_rem;

      if (err) begin
         dec_out.count           = 3'd1;
         dec_out.status          = err_status;
         dec_out.bad_unit        = err_bad;
         dec_out.partial_code    = '0;
         dec_out.units_remaining = 3'd0;
      end else if (do_emit) begin
         dec_out.partial_code    = '0;
         dec_out.units_remaining = 3'd0;
         dec_out.code_point      = emit_cp;
         if ((emit_cp >= CP_SURR_LO && emit_cp <= CP_SURR_HI) || emit_cp > CP_MAX) begin
            dec_out.count  = 3'd1;
            dec_out.status = ST_BAD_CP;
         end else if (dec_in.dest_format == FMT_UTF16) begin
            if (emit_cp <= CP_BMP_MAX) begin
               dec_out.count    = 3'd1;
               dec_out.units[0] = cp21[15:0];
            end else begin
               dec_out.count    = 3'd2;
               dec_out.units[0] = HIGH_SURR | {6'b0, v[19:10]};
               dec_out.units[1] = LOW_SURR | {6'b0, v[9:0]};
            end
         end else if (emit_cp <= CP_1B_MAX) begin
            dec_out.count    = 3'd1;
            dec_out.units[0] = {9'b0, cp21[6:0]};
         end else if (emit_cp <= CP_2B_MAX) begin
            dec_out.count    = 3'd2;
            dec_out.units[0] = {8'b0, 3'b110, cp21[10:6]};
            dec_out.units[1] = {8'b0, 2'b10, cp21[5:0]};
         end else if (emit_cp <= CP_BMP_MAX) begin
            dec_out.count    = 3'd3;
            dec_out.units[0] = {8'b0, 4'b1110, cp21[15:12]};
            dec_out.units[1] = {8'b0, 2'b10, cp21[11:6]};
            dec_out.units[2] = {8'b0, 2'b10, cp21[5:0]};
         end else begin
            dec_out.count    = 3'd4;
            dec_out.units[0] = {8'b0, 5'b11110, cp21[20:18]};
            dec_out.units[1] = {8'b0, 2'b10, cp21[17:12]};
            dec_out.units[2] = {8'b0, 2'b10, cp21[11:6]};
            dec_out.units[3] = {8'b0, 2'b10, cp21[5:0]};
         end
      end
   end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// utf-8 / utf-16 transcoder testbench: three format pairings get directed
// sequences, then every pairing gets random characters, broken sequences and
// noise, and each result is checked field by field against a predicted stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import u8u16_pkg::*;

typedef struct packed {
   logic [15:0] out_unit;
   logic        char_done;
   status_type  status;
   logic [30:0] code_point;
   logic [15:0] bad_unit;
} unit_result_type;

class unit_scoreboard;
   fmt_type         src_fmt;
   fmt_type         dst_fmt;
   logic [30:0]     partial;
   logic [2:0]      remaining;
   unit_result_type expected_units[$];
   int              errors;

   function new();
      src_fmt = FMT_UTF8;
      dst_fmt = FMT_UTF8;
      partial = '0;
      remaining = '0;
      errors = 0;
   endfunction

   function int pending();
      return expected_units.size();
   endfunction

   function void write_format(logic idx, logic value);
      if (idx == REG_SOURCE_FORMAT) begin
         src_fmt = fmt_type'(value);
      end else begin
         dst_fmt = fmt_type'(value);
      end
      partial = '0;
      remaining = '0;
   endfunction

   function void push(logic [15:0] unit, logic done, status_type st, logic [30:0] cp,
                      logic [15:0] bad);
      unit_result_type r;
      r.out_unit = unit;
      r.char_done = done;
      r.status = st;
      r.code_point = cp;
      r.bad_unit = bad;
      expected_units.push_back(r);
   endfunction

   function void report(status_type st, logic [30:0] cp, logic [15:0] bad);
      partial = '0;
      remaining = '0;
      push(16'h0000, 1'b1, st, cp, bad);
   endfunction

   function void encode_char(logic [30:0] cp);
      logic [30:0] v;
      partial = '0;
      remaining = '0;
      if ((cp >= CP_SURR_LO && cp <= CP_SURR_HI) || cp > CP_MAX) begin
         report(ST_BAD_CP, cp, 16'h0000);
      end else if (dst_fmt == FMT_UTF16) begin
         if (cp <= CP_BMP_MAX) begin
            push(cp[15:0], 1'b1, ST_OK, cp, 16'h0000);
         end else begin
            v = cp - CP_SUPP;
            push(HIGH_SURR | {6'd0, v[19:10]}, 1'b0, ST_OK, cp, 16'h0000);
            push(LOW_SURR | {6'd0, v[9:0]}, 1'b1, ST_OK, cp, 16'h0000);
         end
      end else if (cp <= CP_1B_MAX) begin
         push({9'd0, cp[6:0]}, 1'b1, ST_OK, cp, 16'h0000);
      end else if (cp <= CP_2B_MAX) begin
         push({8'd0, 3'b110, cp[10:6]}, 1'b0, ST_OK, cp, 16'h0000);
         push({8'd0, 2'b10, cp[5:0]}, 1'b1, ST_OK, cp, 16'h0000);
      end else if (cp <= CP_BMP_MAX) begin
         push({8'd0, 4'b1110, cp[15:12]}, 1'b0, ST_OK, cp, 16'h0000);
         push({8'd0, 2'b10, cp[11:6]}, 1'b0, ST_OK, cp, 16'h0000);
         push({8'd0, 2'b10, cp[5:0]}, 1'b1, ST_OK, cp, 16'h0000);
      end else begin
         push({8'd0, 5'b11110, cp[20:18]}, 1'b0, ST_OK, cp, 16'h0000);
         push({8'd0, 2'b10, cp[17:12]}, 1'b0, ST_OK, cp, 16'h0000);
         push({8'd0, 2'b10, cp[11:6]}, 1'b0, ST_OK, cp, 16'h0000);
         push({8'd0, 2'b10, cp[5:0]}, 1'b1, ST_OK, cp, 16'h0000);
      end
   endfunction

   function void decode_byte(logic [7:0] b, logic eos);
      int n;
      n = 0;
      if (remaining == 0) begin
         if (b[7] == 1'b0) begin
            encode_char({23'd0, b});
            return;
         end
         while (n < 8 && b[7 - n]) n++;
         if (n == 1 || n > 6) begin
            report(ST_BAD_UNIT, '0, {8'd0, b});
            return;
         end
         partial = {23'd0, b} & ((31'd1 << (7 - n)) - 31'd1);
         remaining = 3'(n - 1);
      end else begin
         if (b[7:6] != 2'b10) begin
            report(ST_BAD_UNIT, '0, {8'd0, b});
            return;
         end
         partial = {partial[24:0], b[5:0]};
         remaining = remaining - 3'd1;
         if (remaining == 0) begin
            encode_char(partial);
            return;
         end
      end
      if (eos) report(ST_INCOMPLETE, '0, 16'h0000);
   endfunction

   function void decode_word(logic [15:0] u, logic eos);
      if (remaining == 0) begin
         if ((u & SURR_MASK) == HIGH_SURR) begin
            partial = {15'd0, u};
            remaining = 3'd1;
            if (eos) report(ST_INCOMPLETE, '0, 16'h0000);
         end else if ((u & SURR_MASK) == LOW_SURR) begin
            report(ST_BAD_UNIT, '0, u);
         end else begin
            encode_char({15'd0, u});
         end
      end else if ((u & SURR_MASK) != LOW_SURR) begin
         report(ST_BAD_UNIT, '0, u);
      end else begin
         encode_char({11'd0, partial[9:0], u[9:0]} + CP_SUPP);
      end
   endfunction

   function void note_request(logic [15:0] unit, logic eos);
      if (src_fmt == FMT_UTF16) begin
         decode_word(unit, eos);
      end else begin
         decode_byte(unit[7:0], eos);
      end
   endfunction

   function void compare_field(string name, logic [30:0] want, logic [30:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endfunction

   function void check_result(logic [15:0] unit, logic done, logic [1:0] st,
                              logic [30:0] cp, logic [15:0] bad);
      unit_result_type want;
      if (expected_units.size() == 0) begin
         $error("result with nothing expected: out_unit %0h status %0d", unit, st);
         errors++;
         return;
      end
      want = expected_units.pop_front();
      compare_field("out_unit", {15'd0, want.out_unit}, {15'd0, unit});
      compare_field("char_done", {30'd0, want.char_done}, {30'd0, done});
      compare_field("status", {29'd0, want.status}, {29'd0, st});
      compare_field("code_point", want.code_point, cp);
      compare_field("bad_unit", {15'd0, want.bad_unit}, {15'd0, bad});
   endfunction
endclass

module tb;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int SETTLE_CYCLES   = 8;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   u8u16_req_if req_ch();
   u8u16_rsp_if rsp_ch();

   unit_scoreboard sb = new();

   bit calm;
   bit hold_off_pending;
   int idle_cycles;

   utf8_utf16_transcoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result side: random stall bursts, one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            sb.note_request(req_ch.code_unit, req_ch.end_of_source);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_ch.out_unit, rsp_ch.char_done, rsp_ch.status,
                            rsp_ch.code_point, rsp_ch.bad_unit);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_psel) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic idx, input logic value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_format(idx, value);
   endtask

   task automatic set_formats(input fmt_type src, input fmt_type dst);
      csr_write(REG_SOURCE_FORMAT, src);
      csr_write(REG_DEST_FORMAT, dst);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_unit(input logic [15:0] unit, input logic eos);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.code_unit     <= unit;
      req_ch.end_of_source <= eos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic drain();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one character, well formed or not, in the current source format
   task automatic send_random_char(input fmt_type src, inout int sent);
      int          kind;
      int          n;
      int          i;
      logic [30:0] cp;
      logic [31:0] v;
      logic [31:0] b;
      logic [7:0]  hi;
      logic [15:0] seq[$];
      kind = $urandom_range(0, 13);
      case (kind)
         0, 1, 2, 3: cp = 31'($urandom_range(0, 32'h7F));
         4, 5:       cp = 31'($urandom_range(32'h80, 32'h7FF));
         6, 7:       cp = 31'($urandom_range(32'h800, 32'hFFFF));
         8, 9:       cp = 31'($urandom_range(32'h10000, 32'h10FFFF));
         10: begin
            if ($urandom_range(0, 1) == 0) cp = 31'($urandom_range(32'h110000, 32'h3FFFFFF));
            else cp = 31'($urandom_range(32'h4000000, 32'h7FFFFFFF));
         end
         11:         cp = 31'($urandom_range(32'hD800, 32'hDFFF));
         default:    cp = 31'($urandom_range(32'h80, 32'h10FFFF));
      endcase
      if (kind == 12 || (src == FMT_UTF16 && cp > CP_MAX)) begin
         seq.push_back(16'($urandom_range(0, 16'hFFFF)));
      end else if (src == FMT_UTF16) begin
         if (cp <= CP_BMP_MAX) begin
            seq.push_back(cp[15:0]);
         end else begin
            v = {1'b0, cp} - {1'b0, CP_SUPP};
            seq.push_back(HIGH_SURR | {6'd0, v[19:10]});
            seq.push_back(LOW_SURR | {6'd0, v[9:0]});
         end
      end else begin
         if (cp <= 31'h7F) n = 1;
         else if (cp <= 31'h7FF) n = 2;
         else if (cp <= 31'hFFFF) n = 3;
         else if (cp <= 31'h1FFFFF) n = 4;
         else if (cp <= 31'h3FFFFFF) n = 5;
         else n = 6;
         // overlong form now and then
         if (n < 6 && $urandom_range(0, 7) == 0) n++;
         if (n == 1) begin
            seq.push_back({8'd0, 1'b0, cp[6:0]});
         end else begin
            b = ((32'hFF << (8 - n)) & 32'hFF) | ({1'b0, cp} >> (6 * (n - 1)));
            seq.push_back(b[15:0]);
            for (i = n - 2; i >= 0; i--) begin
               b = 32'h80 | (({1'b0, cp} >> (6 * i)) & 32'h3F);
               seq.push_back(b[15:0]);
            end
         end
      end
      // truncated sequence
      if (kind == 13 && seq.size() > 1) void'(seq.pop_back());
      foreach (seq[k]) begin
         hi = 8'($urandom_range(0, 255));
         if (src == FMT_UTF8) seq[k][15:8] = hi;
         send_unit(seq[k], $urandom_range(0, 15) == 0);
         sent++;
      end
   endtask

   task automatic run_random(input fmt_type src, input fmt_type dst, input int target,
                             input bit pause_midway);
      int sent;
      bit paused;
      sent = 0;
      paused = 1'b0;
      set_formats(src, dst);
      while (sent < target) begin
         send_random_char(src, sent);
         if (pause_midway && !paused && sent >= target / 2) begin
            wait_results();
            paused = 1'b1;
         end
      end
      drain();
   endtask

   initial begin
      reset                <= 1'b1;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.code_unit     <= '0;
      req_ch.end_of_source <= 1'b0;
      calm = 1'b0;
      hold_off_pending = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // utf-8 to utf-8: four-byte and two-byte characters, upper bits ignored
      set_formats(FMT_UTF8, FMT_UTF8);
      send_unit(16'h00F0, 1'b0);
      send_unit(16'h009F, 1'b0);
      send_unit(16'h0098, 1'b0);
      send_unit(16'h0080, 1'b0);
      send_unit(16'hA5C2, 1'b0);
      send_unit(16'hFFA9, 1'b0);
      send_unit(16'h0000, 1'b1);
      drain();

      // utf-8 to utf-16: invalid leads, bad continuation, bad code points, early end
      set_formats(FMT_UTF8, FMT_UTF16);
      send_unit(16'h0080, 1'b0);
      send_unit(16'h00FF, 1'b0);
      send_unit(16'h00C3, 1'b0);
      send_unit(16'h5A41, 1'b0);
      send_unit(16'h00ED, 1'b0);
      send_unit(16'h00A0, 1'b0);
      send_unit(16'h0080, 1'b0);
      send_unit(16'h00FD, 1'b0);
      repeat (5) send_unit(16'h00BF, 1'b0);
      send_unit(16'h00E2, 1'b0);
      send_unit(16'h0082, 1'b1);
      drain();

      // utf-16 to utf-8: pair, lone low, unpaired high, early end, bmp max
      set_formats(FMT_UTF16, FMT_UTF8);
      send_unit(16'hD83D, 1'b0);
      send_unit(16'hDE00, 1'b0);
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hD800, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'hFFFF, 1'b0);
      send_unit(16'hDBFF, 1'b1);
      drain();

      hold_off_pending = 1'b1;
      run_random(FMT_UTF16, FMT_UTF16, 70, 1'b0);
      run_random(FMT_UTF8, FMT_UTF16, 70, 1'b1);
      run_random(FMT_UTF16, FMT_UTF8, 60, 1'b0);
      calm = 1'b1;
      run_random(FMT_UTF8, FMT_UTF8, 80, 1'b0);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
